// ----- rtl/pixel_channel_remap_normal_z_defines.svh -----
// Assertion macros shared by the RTL
`ifndef PIXEL_CHANNEL_REMAP_NORMAL_Z_DEFINES_SVH
`define PIXEL_CHANNEL_REMAP_NORMAL_Z_DEFINES_SVH

`ifndef ASSERT_OFF
`define PCRNZ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define PCRNZ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PCRNZ_ASSERT(lbl, prop, msg)
`define PCRNZ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/pcrnz_pkg.sv -----
package pcrnz_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_REMAP_EN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RED_SRC  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRN_SRC  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLU_SRC  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ALP_SRC  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NZ_EN    = 3'd5;

	localparam logic signed [9:0] NZ_OFFSET  = 10'sd255;
	localparam logic [16:0]       NZ_UNIT    = 17'd65025;
	localparam logic [15:0]       NZ_RAD_MAX = 16'd16256;
	localparam logic [7:0]        NZ_BIAS    = 8'd128;
	localparam logic [7:0]        CH_FULL    = 8'd255;
	localparam logic [7:0]        CH_ZERO    = 8'd0;

	typedef enum logic [2:0] {
		SEL_RED   = 3'd0,
		SEL_GREEN = 3'd1,
		SEL_BLUE  = 3'd2,
		SEL_ALPHA = 3'd3,
		SEL_ZERO  = 3'd4,
		SEL_FULL  = 3'd5
	} sel_t;

	typedef struct packed {
		logic       remap_en;
		sel_t       red_src;
		sel_t       green_src;
		sel_t       blue_src;
		sel_t       alpha_src;
		logic       nz_en;
	} cfg_t;

	typedef struct packed {
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
		logic [7:0] in_alpha;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
	} pixel_out_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

	typedef struct packed {
		rgba_t ch;
		logic  gate;
	} nz_px_t;

	typedef struct packed {
		nz_px_t     pix;
		logic [15:0] rad;
		logic [8:0]  rem;
		logic [7:0]  root;
	} sq_t;

endpackage

// ----- rtl/pcrnz_remap.sv -----
module pcrnz_remap (
	input  logic                clk,
	input  logic                en,
	input  pcrnz_pkg::cfg_t     cfg,
	input  pcrnz_pkg::pixel_in_t d,
	output pcrnz_pkg::nz_px_t   q_s1
);

	pcrnz_pkg::rgba_t  src;
	pcrnz_pkg::nz_px_t nxt;

	function automatic logic [7:0] pick(pcrnz_pkg::sel_t sel, pcrnz_pkg::rgba_t s,
			logic [7:0] own);
		logic [7:0] r;
		unique case (sel)
			pcrnz_pkg::SEL_RED:   r = s.red;
			pcrnz_pkg::SEL_GREEN: r = s.green;
			pcrnz_pkg::SEL_BLUE:  r = s.blue;
			pcrnz_pkg::SEL_ALPHA: r = s.alpha;
			pcrnz_pkg::SEL_ZERO:  r = pcrnz_pkg::CH_ZERO;
			pcrnz_pkg::SEL_FULL:  r = pcrnz_pkg::CH_FULL;
			default:              r = own;
		endcase
		return r;
	endfunction

	always_comb begin
		src.red   = d.in_red;
		src.green = d.in_green;
		src.blue  = d.in_blue;
		src.alpha = d.in_alpha;
		nxt.ch    = src;
		if (cfg.remap_en) begin
			nxt.ch.red   = pick(cfg.red_src, src, src.red);
			nxt.ch.green = pick(cfg.green_src, src, src.green);
			nxt.ch.blue  = pick(cfg.blue_src, src, src.blue);
			nxt.ch.alpha = pick(cfg.alpha_src, src, src.alpha);
		end
		nxt.gate = cfg.nz_en && (!cfg.remap_en ||
			(cfg.blue_src inside {pcrnz_pkg::SEL_BLUE, pcrnz_pkg::SEL_ZERO,
				pcrnz_pkg::SEL_FULL}));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1 <= nxt;
		end
	end

endmodule

// ----- rtl/pcrnz_square.sv -----
`include "pixel_channel_remap_normal_z_defines.svh"

module pcrnz_square (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en_s2,
	input  logic              en_s3,
	input  logic              vld_s3,
	input  pcrnz_pkg::nz_px_t d,
	output pcrnz_pkg::sq_t    q_s3
);

	logic signed [9:0]  a_v;
	logic signed [9:0]  b_v;
	logic signed [19:0] aa_full;
	logic signed [19:0] bb_full;
	logic [15:0]        aa_s2;
	logic [15:0]        bb_s2;
	pcrnz_pkg::nz_px_t  pix_s2;
	logic [16:0]        sum_v;
	logic [16:0]        diff_v;
	logic [15:0]        rad_v;

	always_comb begin
		a_v     = $signed({1'b0, d.ch.red, 1'b0}) - pcrnz_pkg::NZ_OFFSET;
		b_v     = $signed({1'b0, d.ch.green, 1'b0}) - pcrnz_pkg::NZ_OFFSET;
		aa_full = a_v * a_v;
		bb_full = b_v * b_v;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			aa_s2  <= aa_full[15:0];
			bb_s2  <= bb_full[15:0];
			pix_s2 <= d;
		end
	end

	always_comb begin
		sum_v  = {1'b0, aa_s2} + {1'b0, bb_s2};
		diff_v = pcrnz_pkg::NZ_UNIT - sum_v;
		if (sum_v > pcrnz_pkg::NZ_UNIT) begin
			rad_v = '0;
		end else begin
			rad_v = {2'b00, diff_v[15:2]};
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			q_s3.pix  <= pix_s2;
			q_s3.rad  <= rad_v;
			q_s3.rem  <= '0;
			q_s3.root <= '0;
		end
	end

	`PCRNZ_ASSERT(a_rad_range, vld_s3 |-> (q_s3.rad <= pcrnz_pkg::NZ_RAD_MAX), "radicand out of range")

endmodule

// ----- rtl/pcrnz_sqrt_step.sv -----
`include "pixel_channel_remap_normal_z_defines.svh"

module pcrnz_sqrt_step (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld,
	input  pcrnz_pkg::sq_t d,
	output pcrnz_pkg::sq_t q
);

	logic [10:0] rem_v;
	logic [10:0] cur;
	logic [10:0] trial;
	logic [7:0]  root_v;
	logic [15:0] rad_v;

	// four root digits, two radicand bits each
	always_comb begin
		rem_v  = {2'b00, d.rem};
		root_v = d.root;
		rad_v  = d.rad;
		cur    = '0;
		trial  = '0;
		for (int i = 0; i < 4; i++) begin
			cur   = {rem_v[8:0], rad_v[15:14]};
			trial = {1'b0, root_v, 2'b01};
			rad_v = {rad_v[13:0], 2'b00};
			if (cur >= trial) begin
				rem_v  = cur - trial;
				root_v = {root_v[6:0], 1'b1};
			end else begin
				rem_v  = cur;
				root_v = {root_v[6:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q.pix  <= d.pix;
			q.rad  <= rad_v;
			q.rem  <= rem_v[8:0];
			q.root <= root_v;
		end
	end

	`PCRNZ_ASSERT(a_rem_bound, vld |-> (q.rem <= {q.root, 1'b0}), "root remainder too large")

endmodule

// ----- rtl/pixel_channel_remap_normal_z.sv -----
// Path: an accepted pixel beat is registered in the remap, squares, radicand and two square root
// stages in turn; res_valid is the valid bit of the last of them.
// Throughput: one pixel per cycle through five register stages (remap, squares, radicand,
// two four-digit square root stages); res_ready low holds full stages, empty ones still fill.
// Reset: arst_n clears all stage valid bits and returns the settings to pass-through
// with normal reconstruction off.
`include "pixel_channel_remap_normal_z_defines.svh"

module pixel_channel_remap_normal_z (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 px_valid,
	output logic                                 px_ready,
	input  pcrnz_pkg::pixel_in_t                 px_data,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output pcrnz_pkg::pixel_out_t                res_data,
	input  logic                                 cfg_we,
	input  logic [pcrnz_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [pcrnz_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	pcrnz_pkg::cfg_t   cfg_q;
	pcrnz_pkg::nz_px_t s1;
	pcrnz_pkg::sq_t    s3;
	pcrnz_pkg::sq_t    s4;
	pcrnz_pkg::sq_t    s5;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.remap_en  <= 1'b0;
			cfg_q.red_src   <= pcrnz_pkg::SEL_RED;
			cfg_q.green_src <= pcrnz_pkg::SEL_GREEN;
			cfg_q.blue_src  <= pcrnz_pkg::SEL_BLUE;
			cfg_q.alpha_src <= pcrnz_pkg::SEL_ALPHA;
			cfg_q.nz_en     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				pcrnz_pkg::REG_REMAP_EN: cfg_q.remap_en  <= cfg_wdata[0];
				pcrnz_pkg::REG_RED_SRC:  cfg_q.red_src   <= pcrnz_pkg::sel_t'(cfg_wdata);
				pcrnz_pkg::REG_GRN_SRC:  cfg_q.green_src <= pcrnz_pkg::sel_t'(cfg_wdata);
				pcrnz_pkg::REG_BLU_SRC:  cfg_q.blue_src  <= pcrnz_pkg::sel_t'(cfg_wdata);
				pcrnz_pkg::REG_ALP_SRC:  cfg_q.alpha_src <= pcrnz_pkg::sel_t'(cfg_wdata);
				pcrnz_pkg::REG_NZ_EN:    cfg_q.nz_en     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// advance a stage when it is empty or the one after it advances
	assign rdy5     = !vld_s5 || res_ready;
	assign rdy4     = !vld_s4 || rdy5;
	assign rdy3     = !vld_s3 || rdy4;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign px_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy1) begin
				vld_s1 <= px_valid;
			end
			if (rdy2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy4) begin
				vld_s4 <= vld_s3;
			end
			if (rdy5) begin
				vld_s5 <= vld_s4;
			end
		end
	end

	pcrnz_remap u_remap (
		.clk  (clk),
		.en   (px_valid && rdy1),
		.cfg  (cfg_q),
		.d    (px_data),
		.q_s1 (s1)
	);

	pcrnz_square u_square (
		.clk    (clk),
		.arst_n (arst_n),
		.en_s2  (vld_s1 && rdy2),
		.en_s3  (vld_s2 && rdy3),
		.vld_s3 (vld_s3),
		.d      (s1),
		.q_s3   (s3)
	);

	pcrnz_sqrt_step u_sqrt_hi (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (vld_s3 && rdy4),
		.vld    (vld_s4),
		.d      (s3),
		.q      (s4)
	);

	pcrnz_sqrt_step u_sqrt_lo (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (vld_s4 && rdy5),
		.vld    (vld_s5),
		.d      (s4),
		.q      (s5)
	);

	assign res_valid          = vld_s5;
	assign res_data.out_red   = s5.pix.ch.red;
	assign res_data.out_green = s5.pix.ch.green;
	assign res_data.out_blue  = s5.pix.gate ? (s5.root + pcrnz_pkg::NZ_BIAS) : s5.pix.ch.blue;
	assign res_data.out_alpha = s5.pix.ch.alpha;

	`PCRNZ_ASSERT_NEXT(a_accept_fills_s1, px_valid && px_ready, vld_s1, "accepted beat not captured")
	`PCRNZ_ASSERT_NEXT(a_stall_keeps_s4, vld_s4 && vld_s5 && !res_ready, vld_s4, "beat dropped under stall")
	`PCRNZ_ASSERT(a_nz_upper_half, (res_valid && s5.pix.gate) |-> res_data.out_blue[7], "normal z below bias")

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
	import pcrnz_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT = 2000;

	logic                  clk;
	logic                  arst_n;
	logic                  px_valid;
	logic                  px_ready;
	pixel_in_t             px_data;
	logic                  res_valid;
	logic                  res_ready;
	pixel_out_t            res_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// settings as the block should hold them
	logic             remap_on;
	logic             nz_on;
	logic [3:0][2:0]  src_sel;

	pixel_out_t expected_pixels[$];
	pixel_out_t want;
	int         errors = 0;
	bit         gaps_on = 1'b0;
	bit         stalls_on = 1'b0;
	int         hold_req = 0;
	int         stall_left = 0;

	pixel_channel_remap_normal_z u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.px_valid  (px_valid),
		.px_ready  (px_ready),
		.px_data   (px_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#1 clk = 1'b1;
		#1;
	end

	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] pick_source(logic [2:0] code, logic [3:0][7:0] ch, int own);
		case (code)
			SEL_RED:   return ch[0];
			SEL_GREEN: return ch[1];
			SEL_BLUE:  return ch[2];
			SEL_ALPHA: return ch[3];
			SEL_ZERO:  return 8'h00;
			SEL_FULL:  return 8'hff;
			default:   return ch[own];
		endcase
	endfunction

	function automatic logic [7:0] rebuild_z(logic [7:0] r, logic [7:0] g);
		int a;
		int b;
		int s;
		int root;
		int t;
		a = 2 * int'(r) - 255;
		b = 2 * int'(g) - 255;
		s = 65025 - a * a - b * b;
		if (s < 0)
			s = 0;
		s = s >> 2;
		root = 0;
		for (int k = 7; k >= 0; k--) begin
			t = root | (1 << k);
			if (t * t <= s)
				root = t;
		end
		return 8'(128 + root);
	endfunction

	function automatic pixel_out_t remap_pixel(pixel_in_t p);
		logic [3:0][7:0] ch;
		logic [3:0][7:0] px;
		pixel_out_t      o;
		ch = {p.in_alpha, p.in_blue, p.in_green, p.in_red};
		px = ch;
		if (remap_on)
			for (int c = 0; c < 4; c++)
				px[c] = pick_source(src_sel[c], ch, c);
		if (nz_on && (!remap_on || src_sel[2] == SEL_BLUE || src_sel[2] == SEL_ZERO ||
				src_sel[2] == SEL_FULL))
			px[2] = rebuild_z(px[0], px[1]);
		o.out_red   = px[0];
		o.out_green = px[1];
		o.out_blue  = px[2];
		o.out_alpha = px[3];
		return o;
	endfunction

	function automatic pixel_in_t random_pixel();
		logic [3:0][7:0] v;
		for (int c = 0; c < 4; c++) begin
			case ($urandom_range(0, 7))
				0:       v[c] = 8'h00;
				1:       v[c] = 8'hff;
				default: v[c] = 8'($urandom_range(0, 255));
			endcase
		end
		return v;
	endfunction

	task automatic report_error(string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endtask

	task automatic send_pixel(pixel_in_t p);
		int gap;
		gap = gaps_on ? idle_len() : 0;
		if (gap != 0) begin
			px_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		px_valid <= 1'b1;
		px_data  <= p;
		do @(posedge clk); while (!px_ready);
		expected_pixels.push_back(remap_pixel(p));
	endtask

	task automatic drain();
		px_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_REMAP_EN: remap_on = data[0];
			REG_RED_SRC:  src_sel[0] = data;
			REG_GRN_SRC:  src_sel[1] = data;
			REG_BLU_SRC:  src_sel[2] = data;
			REG_ALP_SRC:  src_sel[3] = data;
			REG_NZ_EN:    nz_on = data[0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(logic [2:0] remap, logic [2:0] r, logic [2:0] g,
			logic [2:0] b, logic [2:0] a, logic [2:0] nz);
		drain();
		set_reg(REG_REMAP_EN, remap);
		set_reg(REG_RED_SRC, r);
		set_reg(REG_GRN_SRC, g);
		set_reg(REG_BLU_SRC, b);
		set_reg(REG_ALP_SRC, a);
		set_reg(REG_NZ_EN, nz);
		cfg_we <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		send_pixel(32'h00000000);
		send_pixel(32'hffffffff);
		send_pixel(32'h55aa55aa);
		send_pixel(32'haa55aa55);
	endtask

	task automatic test_selectors();
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		for (int code = 0; code < 8; code++) begin
			apply_settings(3'd1, 3'(code), 3'(code + 1), 3'(code + 2), 3'(code + 3), 3'd0);
			send_pixel(32'h1e2d3c4b);
		end
	endtask

	task automatic test_normal_z();
		apply_settings(3'd0, SEL_RED, SEL_GREEN, SEL_BLUE, SEL_ALPHA, 3'd1);
		send_pixel(32'h00001122);
		send_pixel(32'hffff3344);
		send_pixel(32'h80805566);
		send_pixel(32'hff807788);
		send_pixel(32'h008099aa);
		send_pixel(32'h7f7fbbcc);
	endtask

	task automatic test_reconstruction_gate();
		apply_settings(3'd1, SEL_RED, SEL_GREEN, SEL_GREEN, SEL_ALPHA, 3'd1);
		send_pixel(32'h40c02233);
		apply_settings(3'd1, SEL_RED, SEL_GREEN, SEL_ZERO, SEL_ALPHA, 3'd1);
		send_pixel(32'h40c02233);
		apply_settings(3'd1, SEL_RED, SEL_GREEN, 3'd7, SEL_ALPHA, 3'd1);
		send_pixel(32'h40c02233);
		apply_settings(3'd1, SEL_ALPHA, SEL_BLUE, SEL_FULL, SEL_RED, 3'd1);
		send_pixel(32'h40c02233);
	endtask

	task automatic test_wide_writes();
		drain();
		set_reg(REG_REMAP_EN, 3'b110);
		set_reg(REG_NZ_EN, 3'b111);
		set_reg(REG_UNUSED_A, 3'b101);
		set_reg(REG_UNUSED_B, 3'b111);
		cfg_we <= 1'b0;
		send_pixel(32'hc0401234);
		drain();
		set_reg(REG_REMAP_EN, 3'b011);
		set_reg(REG_NZ_EN, 3'b010);
		set_reg(REG_UNUSED_B, 3'b000);
		cfg_we <= 1'b0;
		send_pixel(32'h13579bdf);
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < 10; phase++) begin
			gaps_on   = (phase % 3 != 2);
			stalls_on = gaps_on;
			if (phase == 0)
				apply_settings(3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0);
			else if (phase == 1)
				apply_settings(3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7);
			else
				apply_settings(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
					3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
					3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
			for (int n = 0; n < 45; n++)
				send_pixel(random_pixel());
		end
	endtask

	task automatic test_backpressure();
		apply_settings(3'd1, SEL_RED, SEL_GREEN, SEL_ZERO, SEL_ALPHA, 3'd1);
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		hold_req  = 60;
		for (int n = 0; n < 40; n++)
			send_pixel(random_pixel());
	endtask

	// hold off the result side: a requested long stall first, then random ones while stalls_on is set
	initial begin
		res_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				stall_left = hold_req;
				hold_req   = 0;
			end else if (stall_left == 0 && stalls_on) begin
				stall_left = idle_len();
			end
			if (stall_left != 0) begin
				res_ready <= 1'b0;
				stall_left--;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (expected_pixels.size() == 0) begin
				report_error($sformatf("result beat with nothing outstanding: %h", res_data));
			end else begin
				want = expected_pixels.pop_front();
				if (res_data.out_red !== want.out_red || res_data.out_green !== want.out_green ||
						res_data.out_blue !== want.out_blue ||
						res_data.out_alpha !== want.out_alpha)
					report_error($sformatf(
						"pixel mismatch: expected r%0d g%0d b%0d a%0d, got r%0d g%0d b%0d a%0d",
						want.out_red, want.out_green, want.out_blue, want.out_alpha,
						res_data.out_red, res_data.out_green, res_data.out_blue,
						res_data.out_alpha));
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		px_valid  = 1'b0;
		px_data   = '0;
		cfg_we    = 1'b0;
		cfg_idx   = '0;
		cfg_wdata = '0;
		remap_on  = 1'b0;
		nz_on     = 1'b0;
		src_sel   = {SEL_ALPHA, SEL_BLUE, SEL_GREEN, SEL_RED};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_selectors();
		test_normal_z();
		test_reconstruction_gate();
		test_wide_writes();
		test_random_settings();
		test_backpressure();
		px_valid <= 1'b0;
		for (int w = 0; w < DRAIN_LIMIT && expected_pixels.size() != 0; w++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_pixels.size() != 0)
			report_error($sformatf("%0d pixels never returned", expected_pixels.size()));
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#400000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
